[rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the sequential list engine: command and
// status codes, sequencer states and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int CMD_W = 3;
   localparam int POS_W = 7;
   localparam int VAL_W = 16;
   localparam int STS_W = 3;
   localparam int LEN_W = 7;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_ELEM_WIDTH = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 3'd0,
      CMD_DELETE  = 3'd1,
      CMD_GET     = 3'd2,
      CMD_LOCATE  = 3'd3,
      CMD_DEL_MIN = 3'd4,
      CMD_SORT    = 3'd5
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_PUT,
      S_DEL_SHIFT,
      S_GET_READ,
      S_DRAIN,
      S_LOC_SCAN,
      S_MIN_SCAN,
      S_MIN_PUT,
      S_SORT_OUTER,
      S_SORT_TAKE,
      S_SORT_INNER,
      S_SORT_CMP,
      S_FINISH
   } state_type;

endpackage

[rtl/sle_ram.sv]
// ----------------------------------------------------------------------------
// sle_ram
// Entry store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
   parameter int DEPTH = sle_pkg::DEF_CAPACITY,
   parameter int WIDTH = sle_pkg::DEF_ELEM_WIDTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sequential_list_engine.sv]
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed values in a single-port-write entry store with a
// count, driven by insert, delete, get, locate, delete-minimum and sort.
//
// Usage: a command word enters on req_ (valid/stall); one result word
// leaves on rsp_ (valid/stall) for every command. The engine works on one
// command at a time; req_stall is low only while the sequencer is idle.
// Every entry move or scan step is one access of the store's read port,
// so the cost of insert and delete grows with the entries from the
// position up, locate (at most) and delete-minimum with the list length,
// sort is quadratic at worst, and get, errors and unused codes do not
// depend on the list.
// Results sit in an output register, so a new command is taken while the
// previous result still waits; a command that finishes while that register
// is held by rsp_stall waits in its last state until the word is taken.
// Reset empties the list (count to zero); the store itself is
// not cleared, entries are only read after they are written.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
   parameter int CAPACITY   = sle_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = sle_pkg::DEF_ELEM_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sle_pkg::CMD_W-1:0]         req_cmd,
   input  logic [sle_pkg::POS_W-1:0]         req_position,
   input  logic signed [sle_pkg::VAL_W-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sle_pkg::STS_W-1:0]         rsp_status,
   output logic signed [sle_pkg::VAL_W-1:0]  rsp_result_value,
   output logic [sle_pkg::POS_W-1:0]         rsp_result_position,
   output logic [sle_pkg::LEN_W-1:0]         rsp_list_length
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;
   localparam int EW = ELEM_WIDTH;

   sle_pkg::state_type  state_ff, state_in;
   sle_pkg::status_type sts_ff, sts_in;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] jx_ff, jx_in;
   logic [EW-1:0] val_ff, val_in;
   logic [EW-1:0] t_ff, t_in;
   logic [EW-1:0] min_ff, min_in;
   logic [EW-1:0] last_ff, last_in;
   logic [AW-1:0] at_ff, at_in;

   logic          wv_ff, wv_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic          cv_ff, cv_in;
   logic          sv_ff, sv_in;
   logic [AW-1:0] six_ff, six_in;

   logic signed [sle_pkg::VAL_W-1:0] rval_ff, rval_in;
   logic [sle_pkg::POS_W-1:0]        rpos_ff, rpos_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sle_pkg::STS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [sle_pkg::VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [sle_pkg::POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [sle_pkg::LEN_W-1:0]        rsp_len_ff, rsp_len_in;

   logic          ram_we;
   logic [AW-1:0] ram_wa;
   logic [EW-1:0] ram_wd;
   logic          ram_re;
   logic [AW-1:0] ram_ra;
   logic [EW-1:0] rd_data;

   logic [XW-1:0] pos_x;
   logic [XW-1:0] cnt_x;
   logic          pos_zero;

   sle_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (rd_data)
   );

   assign pos_x    = XW'(req_position);
   assign cnt_x    = XW'(cnt_ff);
   assign pos_zero = (req_position == '0);

   assign req_stall = (state_ff != sle_pkg::S_IDLE);

   always_comb begin
      state_in     = state_ff;
      sts_in       = sts_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      ptr_in       = ptr_ff;
      jx_in        = jx_ff;
      val_in       = val_ff;
      t_in         = t_ff;
      min_in       = min_ff;
      last_in      = last_ff;
      at_in        = at_ff;
      wv_in        = 1'b0;
      wa_in        = wa_ff;
      cv_in        = 1'b0;
      sv_in        = 1'b0;
      six_in       = six_ff;
      rval_in      = rval_ff;
      rpos_in      = rpos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_len_in    = rsp_len_ff;
      ram_we       = 1'b0;
      ram_wa       = wa_ff;
      ram_wd       = rd_data;
      ram_re       = 1'b0;
      ram_ra       = AW'(ptr_ff);

      // data returning from the read issued last cycle
      if (wv_ff) begin
         ram_we = 1'b1;
      end
      if (cv_ff) begin
         rval_in = sle_pkg::VAL_W'($signed(rd_data));
      end

      unique case (state_ff)
         sle_pkg::S_IDLE: begin
            if (req_valid) begin
               n_in    = cnt_ff;
               k_in    = CW'(pos_x - XW'(1));
               val_in  = EW'($signed(req_value));
               sts_in  = sle_pkg::ST_OK;
               rval_in = '0;
               rpos_in = '0;
               unique case (sle_pkg::cmd_type'(req_cmd))
                  sle_pkg::CMD_INSERT: begin
                     if (cnt_ff == CW'(CAPACITY)) begin
                        sts_in   = sle_pkg::ST_FULL;
                        state_in = sle_pkg::S_FINISH;
                     end else if (pos_zero || pos_x > cnt_x + XW'(1)) begin
                        sts_in   = sle_pkg::ST_BADPOS;
                        state_in = sle_pkg::S_FINISH;
                     end else begin
                        ptr_in   = cnt_ff;
                        cnt_in   = cnt_ff + CW'(1);
                        state_in = sle_pkg::S_INS_SHIFT;
                     end
                  end
                  sle_pkg::CMD_DELETE: begin
                     if (cnt_ff == '0) begin
                        sts_in   = sle_pkg::ST_EMPTY;
                        state_in = sle_pkg::S_FINISH;
                     end else if (pos_zero || pos_x > cnt_x) begin
                        sts_in   = sle_pkg::ST_BADPOS;
                        state_in = sle_pkg::S_FINISH;
                     end else begin
                        ptr_in   = CW'(pos_x - XW'(1));
                        cnt_in   = cnt_ff - CW'(1);
                        state_in = sle_pkg::S_DEL_SHIFT;
                     end
                  end
                  sle_pkg::CMD_GET: begin
                     if (pos_zero || pos_x > cnt_x) begin
                        sts_in   = sle_pkg::ST_BADPOS;
                        state_in = sle_pkg::S_FINISH;
                     end else begin
                        state_in = sle_pkg::S_GET_READ;
                     end
                  end
                  sle_pkg::CMD_LOCATE: begin
                     sts_in   = sle_pkg::ST_NOTFOUND;
                     ptr_in   = '0;
                     state_in = sle_pkg::S_LOC_SCAN;
                  end
                  sle_pkg::CMD_DEL_MIN: begin
                     if (cnt_ff == '0) begin
                        sts_in   = sle_pkg::ST_EMPTY;
                        state_in = sle_pkg::S_FINISH;
                     end else begin
                        ptr_in   = '0;
                        cnt_in   = cnt_ff - CW'(1);
                        state_in = sle_pkg::S_MIN_SCAN;
                     end
                  end
                  sle_pkg::CMD_SORT: begin
                     ptr_in   = CW'(1);
                     state_in = sle_pkg::S_SORT_OUTER;
                  end
                  default: begin
                     state_in = sle_pkg::S_FINISH;
                  end
               endcase
            end
         end

         // move entries up, top first, then drop the new value in
         sle_pkg::S_INS_SHIFT: begin
            if (ptr_ff != k_ff) begin
               ram_re = 1'b1;
               ram_ra = AW'(ptr_ff - CW'(1));
               wv_in  = 1'b1;
               wa_in  = AW'(ptr_ff);
               ptr_in = ptr_ff - CW'(1);
            end else begin
               state_in = sle_pkg::S_INS_PUT;
            end
         end
         sle_pkg::S_INS_PUT: begin
            ram_we   = 1'b1;
            ram_wa   = AW'(k_ff);
            ram_wd   = val_ff;
            state_in = sle_pkg::S_FINISH;
         end

         // first read returns the removed word, the rest move down by one
         sle_pkg::S_DEL_SHIFT: begin
            if (ptr_ff != n_ff) begin
               ram_re = 1'b1;
               if (ptr_ff == k_ff) begin
                  cv_in = 1'b1;
               end else begin
                  wv_in = 1'b1;
                  wa_in = AW'(ptr_ff - CW'(1));
               end
               ptr_in = ptr_ff + CW'(1);
            end else begin
               state_in = sle_pkg::S_DRAIN;
            end
         end
         sle_pkg::S_GET_READ: begin
            ram_re   = 1'b1;
            ram_ra   = AW'(k_ff);
            cv_in    = 1'b1;
            state_in = sle_pkg::S_DRAIN;
         end
         sle_pkg::S_DRAIN: begin
            state_in = sle_pkg::S_FINISH;
         end

         sle_pkg::S_LOC_SCAN: begin
            if (sv_ff && rd_data == val_ff) begin
               sts_in   = sle_pkg::ST_OK;
               rpos_in  = sle_pkg::POS_W'(CW'(six_ff) + CW'(1));
               state_in = sle_pkg::S_FINISH;
            end else if (ptr_ff != n_ff) begin
               ram_re = 1'b1;
               sv_in  = 1'b1;
               six_in = AW'(ptr_ff);
               ptr_in = ptr_ff + CW'(1);
            end else if (!sv_ff) begin
               state_in = sle_pkg::S_FINISH;
            end
         end

         // the last entry is caught on its way past to fill the hole
         sle_pkg::S_MIN_SCAN: begin
            if (sv_ff) begin
               if (six_ff == '0 || $signed(rd_data) < $signed(min_ff)) begin
                  min_in = rd_data;
                  at_in  = six_ff;
               end
               if (CW'(six_ff) == n_ff - CW'(1)) begin
                  last_in = rd_data;
               end
            end
            if (ptr_ff != n_ff) begin
               ram_re = 1'b1;
               sv_in  = 1'b1;
               six_in = AW'(ptr_ff);
               ptr_in = ptr_ff + CW'(1);
            end else if (!sv_ff) begin
               state_in = sle_pkg::S_MIN_PUT;
            end
         end
         sle_pkg::S_MIN_PUT: begin
            ram_we   = 1'b1;
            ram_wa   = at_ff;
            ram_wd   = last_ff;
            rval_in  = sle_pkg::VAL_W'($signed(min_ff));
            state_in = sle_pkg::S_FINISH;
         end

         sle_pkg::S_SORT_OUTER: begin
            if (ptr_ff >= n_ff) begin
               state_in = sle_pkg::S_FINISH;
            end else begin
               ram_re   = 1'b1;
               ram_ra   = AW'(ptr_ff);
               state_in = sle_pkg::S_SORT_TAKE;
            end
         end
         sle_pkg::S_SORT_TAKE: begin
            t_in     = rd_data;
            jx_in    = ptr_ff;
            state_in = sle_pkg::S_SORT_INNER;
         end
         sle_pkg::S_SORT_INNER: begin
            if (jx_ff == '0) begin
               ram_we   = 1'b1;
               ram_wa   = AW'(jx_ff);
               ram_wd   = t_ff;
               ptr_in   = ptr_ff + CW'(1);
               state_in = sle_pkg::S_SORT_OUTER;
            end else begin
               ram_re   = 1'b1;
               ram_ra   = AW'(jx_ff - CW'(1));
               state_in = sle_pkg::S_SORT_CMP;
            end
         end
         sle_pkg::S_SORT_CMP: begin
            ram_we = 1'b1;
            ram_wa = AW'(jx_ff);
            if ($signed(t_ff) < $signed(rd_data)) begin
               ram_wd   = rd_data;
               jx_in    = jx_ff - CW'(1);
               state_in = sle_pkg::S_SORT_INNER;
            end else begin
               ram_wd   = t_ff;
               ptr_in   = ptr_ff + CW'(1);
               state_in = sle_pkg::S_SORT_OUTER;
            end
         end

         sle_pkg::S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sts_ff;
               rsp_value_in  = rval_ff;
               rsp_pos_in    = rpos_ff;
               rsp_len_in    = sle_pkg::LEN_W'(cnt_ff);
               state_in      = sle_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sle_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::S_IDLE;
         cnt_ff       <= '0;
         wv_ff        <= 1'b0;
         cv_ff        <= 1'b0;
         sv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wv_ff        <= wv_in;
         cv_ff        <= cv_in;
         sv_ff        <= sv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sts_ff        <= sts_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      ptr_ff        <= ptr_in;
      jx_ff         <= jx_in;
      val_ff        <= val_in;
      t_ff          <= t_in;
      min_ff        <= min_in;
      last_ff       <= last_in;
      at_ff         <= at_in;
      wa_ff         <= wa_in;
      six_ff        <= six_in;
      rval_ff       <= rval_in;
      rpos_ff       <= rpos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_value    = rsp_value_ff;
   assign rsp_result_position = rsp_pos_ff;
   assign rsp_list_length     = rsp_len_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      wv_ff && ram_re |-> ram_ra != wa_ff)
      else $error("read of an entry whose move is still pending");

   a_one_return: assert property (@(posedge clock) disable iff (reset)
      $onehot0({wv_ff, cv_ff, sv_ff}))
      else $error("returning read word claimed twice");

   a_put_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sle_pkg::S_INS_PUT || state_ff == sle_pkg::S_SORT_INNER ||
       state_ff == sle_pkg::S_SORT_CMP || state_ff == sle_pkg::S_MIN_PUT) |-> !wv_ff)
      else $error("second write into the store in one cycle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == sle_pkg::S_FINISH))
      else $error("result word raised outside the finish step");

endmodule
